@@ src/swv_pkg.sv @@
// swv_pkg: shared constants for the sliding-window variance block.
// No dependencies; used by swv_num, swv_div, sliding_window_variance_top and the testbench.
package swv_pkg;

  // sample and result field widths
  localparam int VAR_W     = 34;
  localparam int CIDX_W    = 16;
  localparam int SAMPLE_W  = 16;
  localparam int FRAC_BITS = 4;

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // register file
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;
  localparam int HW_REG_W = 7;

  localparam logic [CFG_AW-1:0]   ADDR_HALF_WINDOW = 2'd0;
  localparam logic [HW_REG_W-1:0] HALF_WINDOW_RST  = 7'd1;

endpackage

@@ src/swv_ram.sv @@
// swv_ram: single-port-write, single-port-read sample store with registered read.
// Stand-alone; instantiated by sliding_window_variance_top.
module swv_ram #(
  parameter int DEPTH = 255,
  parameter int AW    = 8,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/swv_num.sv @@
// swv_num: two-stage numerator pipeline, N*S2 - S1^2 scaled by 2^FRAC_BITS,
// plus the divisor N*(N-1). Uses swv_pkg.
module swv_num #(
  parameter int WIN_BITS = 8,
  parameter int SUM_W    = 24,
  parameter int SQ_W     = 40,
  parameter int DEN_W    = 16,
  parameter int NUM_W    = 52
) (
  input  logic                    clk,
  input  logic [WIN_BITS-1:0]     n,
  input  logic signed [SUM_W-1:0] s1,
  input  logic [SQ_W-1:0]         s2,
  output logic [NUM_W-1:0]        num,
  output logic [DEN_W-1:0]        den
);

  localparam int PW = 2 * SUM_W;

  logic [SUM_W-1:0] mag;
  logic [PW-1:0]    pa_r;
  logic [PW-1:0]    pb_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_r;

  assign mag = s1[SUM_W-1] ? SUM_W'(-s1) : SUM_W'(s1);

  // stage 1: products
  always_ff @(posedge clk) begin
    pa_r  <= PW'(n) * PW'(s2);
    pb_r  <= PW'(mag) * PW'(mag);
    den_r <= DEN_W'(n) * DEN_W'(n - WIN_BITS'(1));
  end

  // stage 2: difference is never negative (Cauchy-Schwarz)
  always_ff @(posedge clk) begin
    num_r <= NUM_W'({pa_r - pb_r, {swv_pkg::FRAC_BITS{1'b0}}});
  end

  assign num = num_r;
  assign den = den_r;

endmodule

@@ src/swv_div.sv @@
// swv_div: restoring divider, one quotient bit per cycle, saturating at VAR_MAX.
// Uses swv_pkg; instantiated by sliding_window_variance_top.
module swv_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic                       done,
  output logic [swv_pkg::VAR_W-1:0]  quot
);

  localparam int QW    = swv_pkg::VAR_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [DEN_W:0]     rem_r, rem_nxt;
  logic [QW-1:0]      low_r, low_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [NUM_W-1:0]   hi;
  logic               sat;
  logic [DEN_W:0]     trial;
  logic               ge;

  assign hi    = num >> QW;
  // quotient overflows QW bits exactly when num / 2^QW reaches den
  assign sat   = hi >= NUM_W'(den);
  assign trial = {rem_r[DEN_W-1:0], low_r[QW-1]};
  assign ge    = trial >= {1'b0, den};

  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      if (sat) begin
        low_nxt  = swv_pkg::VAR_MAX;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = (DEN_W + 1)'(hi);
        low_nxt  = num[QW-1:0];
        cnt_nxt  = CNT_W'(QW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, den} : trial;
      low_nxt = {low_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = low_r;

endmodule

@@ src/sliding_window_variance_top.sv @@
// sliding_window_variance_top: centered moving unbiased variance over 2h+1 samples.
// Uses swv_pkg, swv_ram, swv_num and swv_div.
//
// One sample is taken at a time. A sample whose window is not yet full passes
// through the sum update and returns to idle for the next accept. A sample that
// completes a window goes through the sum update, two multiply stages, divider
// load, 34 divider steps, done pickup and result load before the next accept,
// paced by the one-bit-per-cycle restoring divider. A saturating result skips
// the divider steps. A result waits to load while an earlier result is stalled
// in the output register, which delays the next accept. The sample ring lives
// in a RAM with registered read; the outgoing sample is read before its slot is
// rewritten. A finished result sits in the output register while the next
// sample is accepted. Writing half_window (address 0) also starts a new vector;
// out-of-range values act as 1 or MAX_HALF_WINDOW. There is no clearing pass after reset.
module sliding_window_variance_top #(
  parameter int MAX_HALF_WINDOW = 127,
  parameter int SAMPLE_BITS     = 16,
  parameter int MAX_VECTOR_LEN  = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_end_of_vector,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swv_pkg::VAR_W-1:0]           out_window_variance,
  output logic [swv_pkg::CIDX_W-1:0]          out_centre_index,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swv_pkg::CFG_AW-1:0]          paddr,
  input  logic [swv_pkg::CFG_DW-1:0]          pwdata,
  output logic [swv_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int SB       = SAMPLE_BITS;
  localparam int HW_BITS  = $clog2(MAX_HALF_WINDOW + 1);
  localparam int WIN_BITS = HW_BITS + 1;
  localparam int DEPTH    = 2 * MAX_HALF_WINDOW + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int SUM_W    = SB + WIN_BITS;
  localparam int SQ_W     = 2 * SB + WIN_BITS;
  localparam int VEC_BITS = $clog2(MAX_VECTOR_LEN);
  localparam int HC_W     = (HW_BITS > swv_pkg::HW_REG_W) ? HW_BITS : swv_pkg::HW_REG_W;
  localparam int CX_W     = ((VEC_BITS > HW_BITS) ? VEC_BITS : HW_BITS) + 2;
  localparam int DEN_W    = 2 * WIN_BITS;
  localparam int NUM_RAW  = 2 * SUM_W + swv_pkg::FRAC_BITS;
  localparam int NUM_W    = (NUM_RAW > swv_pkg::VAR_W) ? NUM_RAW : swv_pkg::VAR_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_UPD   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_SUB   = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic [swv_pkg::HW_REG_W-1:0]  half_window_r;
  logic signed [SUM_W-1:0]       s1_r;
  logic [SQ_W-1:0]               s2_r;
  logic [VEC_BITS-1:0]           cnt_r;
  logic [AW-1:0]                 wp_r;
  logic [WIN_BITS-1:0]           fill_r;

  logic signed [SB-1:0]          smp_r;
  logic [2*SB-1:0]               sq_r;
  logic                          eov_r;

  logic signed [SUM_W-1:0]       op_s1_r;
  logic [SQ_W-1:0]               op_s2_r;
  logic [WIN_BITS-1:0]           op_n_r;
  logic [VEC_BITS-1:0]           centre_r;

  logic                          out_valid_r;
  logic [swv_pkg::VAR_W-1:0]     out_var_r;
  logic [swv_pkg::CIDX_W-1:0]    out_cidx_r;

  logic [HC_W-1:0]               hw_ext;
  logic [HW_BITS-1:0]            h_eff;
  logic [WIN_BITS-1:0]           n_win;
  logic                          in_acc;
  logic                          cfg_wr;
  logic signed [SB-1:0]          smp_c;
  logic signed [2*SB-1:0]        smp_sq_c;
  logic [AW:0]                   wp_x, n_x;
  logic [AW-1:0]                 rd_addr;
  logic [SB-1:0]                 ram_rdata;
  logic signed [SB-1:0]          old_smp;
  logic signed [2*SB-1:0]        old_sq;
  logic                          drop;
  logic [WIN_BITS-1:0]           fill_inc;
  logic                          produce;
  logic signed [SUM_W-1:0]       s1_nxt;
  logic [SQ_W-1:0]               s2_nxt;
  logic [CX_W-1:0]               cnt_x, h_x, centre_x;
  logic [VEC_BITS-1:0]           cnt_inc;
  logic [AW-1:0]                 wp_inc;
  logic                          out_free;
  logic [NUM_W-1:0]              num;
  logic [DEN_W-1:0]              den;
  logic                          div_done;
  logic [swv_pkg::VAR_W-1:0]     div_quot;

  // effective half window
  assign hw_ext = HC_W'(half_window_r);
  always_comb begin
    if (hw_ext == '0) begin
      h_eff = HW_BITS'(1);
    end else if (hw_ext > HC_W'(MAX_HALF_WINDOW)) begin
      h_eff = HW_BITS'(MAX_HALF_WINDOW);
    end else begin
      h_eff = HW_BITS'(hw_ext);
    end
  end
  assign n_win = {h_eff, 1'b1};

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr == swv_pkg::ADDR_HALF_WINDOW);
  assign pready   = 1'b1;
  assign prdata   = (paddr == swv_pkg::ADDR_HALF_WINDOW) ?
                    swv_pkg::CFG_DW'(half_window_r) : '0;

  // low SAMPLE_BITS of the port, sign taken from the top kept bit
  assign smp_c    = SB'($unsigned(in_sample));
  assign smp_sq_c = smp_c * smp_c;

  // ring slot of the sample leaving the window
  assign wp_x = {1'b0, wp_r};
  assign n_x  = (AW + 1)'(n_win);
  assign rd_addr = (wp_x >= n_x) ? AW'(wp_x - n_x)
                                 : AW'(wp_x + (AW + 1)'(DEPTH) - n_x);

  swv_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (SB)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == ST_UPD),
    .waddr (wp_r),
    .wdata (smp_r),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign old_smp  = ram_rdata;
  assign old_sq   = old_smp * old_smp;
  assign drop     = fill_r >= n_win;
  assign fill_inc = drop ? fill_r : fill_r + WIN_BITS'(1);
  assign produce  = fill_inc >= n_win;
  assign s1_nxt   = s1_r + SUM_W'(smp_r) - (drop ? SUM_W'(old_smp) : '0);
  assign s2_nxt   = s2_r + SQ_W'(sq_r) - (drop ? SQ_W'(old_sq) : '0);

  assign cnt_x    = CX_W'(cnt_r);
  assign h_x      = CX_W'(h_eff);
  assign centre_x = (cnt_x >= h_x) ? cnt_x - h_x
                                   : cnt_x + CX_W'(MAX_VECTOR_LEN) - h_x;
  assign cnt_inc  = (cnt_r == VEC_BITS'(MAX_VECTOR_LEN - 1)) ? '0 : cnt_r + VEC_BITS'(1);
  assign wp_inc   = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);

  swv_num #(
    .WIN_BITS (WIN_BITS),
    .SUM_W    (SUM_W),
    .SQ_W     (SQ_W),
    .DEN_W    (DEN_W),
    .NUM_W    (NUM_W)
  ) u_num (
    .clk (clk),
    .n   (op_n_r),
    .s1  (op_s1_r),
    .s2  (op_s2_r),
    .num (num),
    .den (den)
  );

  swv_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_START),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:   state_nxt = produce ? ST_MUL : ST_IDLE;
      ST_MUL:   state_nxt = ST_SUB;
      ST_SUB:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control and vector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      half_window_r <= swv_pkg::HALF_WINDOW_RST;
      s1_r          <= '0;
      s2_r          <= '0;
      cnt_r         <= '0;
      wp_r          <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        half_window_r <= pwdata[swv_pkg::HW_REG_W-1:0];
        s1_r          <= '0;
        s2_r          <= '0;
        cnt_r         <= '0;
        wp_r          <= '0;
        fill_r        <= '0;
      end else if (state_r == ST_UPD) begin
        if (eov_r) begin
          s1_r   <= '0;
          s2_r   <= '0;
          cnt_r  <= '0;
          wp_r   <= '0;
          fill_r <= '0;
        end else begin
          s1_r   <= s1_nxt;
          s2_r   <= s2_nxt;
          cnt_r  <= cnt_inc;
          wp_r   <= wp_inc;
          fill_r <= fill_inc;
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= smp_c;
      sq_r  <= (2 * SB)'(smp_sq_c);
      eov_r <= in_end_of_vector;
    end
    if (state_r == ST_UPD) begin
      op_s1_r  <= s1_nxt;
      op_s2_r  <= s2_nxt;
      op_n_r   <= n_win;
      centre_r <= VEC_BITS'(centre_x);
    end
    if (state_r == ST_DONE && out_free) begin
      out_var_r  <= div_quot;
      out_cidx_r <= swv_pkg::CIDX_W'(centre_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_window_variance = out_var_r;
  assign out_centre_index    = out_cidx_r;

endmodule

@@ src/swv_chk.sv @@
// swv_chk: port-level checks for sliding_window_variance_top, attached by bind.
// Uses only the top-level ports; no package dependency.
module swv_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [33:0] out_window_variance,
  input logic [15:0] out_centre_index
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_variance) &&
                               $stable(out_centre_index))
    else $error("result changed while stalled");

  // one sample in flight: the cycle after a transfer the input is stalled
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // a new result is only loaded while a sample is being worked on
  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a sample in work");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sliding_window_variance_top swv_chk u_swv_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_window_variance (out_window_variance),
  .out_centre_index    (out_centre_index)
);

@@ tb/swv_variance_checker.sv @@
`timescale 1ns / 1ps
// swv_variance_checker: watches the sample, result and register ports of the
// sliding-window variance block, predicts each result and compares in order. Uses swv_pkg.
module swv_variance_checker #(
  parameter int MAX_HALF_WINDOW = 127,
  parameter int MAX_VECTOR_LEN  = 65536
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [swv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_end_of_vector,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [swv_pkg::VAR_W-1:0]           out_window_variance,
  input  logic [swv_pkg::CIDX_W-1:0]          out_centre_index,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [swv_pkg::CFG_AW-1:0]          paddr,
  input  logic [swv_pkg::CFG_DW-1:0]          pwdata,
  output int                                  error_count,
  output int                                  pending_results
);

  localparam int RING_DEPTH  = 2 * MAX_HALF_WINDOW + 1;
  localparam int MAX_PRINTED = 200;

  typedef struct packed {
    logic [swv_pkg::VAR_W-1:0]  variance;
    logic [swv_pkg::CIDX_W-1:0] centre;
  } variance_result_t;

  variance_result_t expected_variances[$];
  variance_result_t want;
  longint           ring[RING_DEPTH];
  longint           sum_s1;
  longint unsigned  sum_s2;
  int unsigned      half_w;
  int unsigned      next_index;
  int unsigned      wr_slot;
  int unsigned      fill;
  int               errors = 0;

  task automatic report_mismatch(input string what);
    if (errors < MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic restart_vector();
    foreach (ring[i]) ring[i] = 0;
    sum_s1     = 0;
    sum_s2     = 0;
    next_index = 0;
    wr_slot    = 0;
    fill       = 0;
  endtask

  // Slide the window by one sample; queue a result once the window is full.
  task automatic slide_window(input logic signed [swv_pkg::SAMPLE_W-1:0] s, input logic last);
    int unsigned      h;
    int unsigned      n;
    longint           sv;
    longint           old;
    logic [127:0]     numer;
    logic [127:0]     mag;
    logic [127:0]     denom;
    logic [127:0]     quot;
    variance_result_t r;
    h = half_w;
    if (h < 1) h = 1;
    if (h > MAX_HALF_WINDOW) h = MAX_HALF_WINDOW;
    n  = 2 * h + 1;
    sv = s;
    if (fill >= n) begin
      // oldest sample leaves before its slot is reused
      old = ring[(wr_slot + RING_DEPTH - n) % RING_DEPTH];
      sum_s1 -= old;
      sum_s2 -= old * old;
    end else begin
      fill++;
    end
    ring[wr_slot] = sv;
    wr_slot = (wr_slot + 1) % RING_DEPTH;
    sum_s1 += sv;
    sum_s2 += sv * sv;
    if (fill >= n) begin
      mag   = (sum_s1 < 0) ? 128'(-sum_s1) : 128'(sum_s1);
      numer = (128'(n) * 128'(sum_s2) - mag * mag) << swv_pkg::FRAC_BITS;
      denom = 128'(n) * 128'(n - 1);
      quot  = (numer >= (denom << swv_pkg::VAR_W)) ? 128'(swv_pkg::VAR_MAX) : numer / denom;
      r.variance = quot[swv_pkg::VAR_W-1:0];
      r.centre   = swv_pkg::CIDX_W'((next_index + MAX_VECTOR_LEN - h) % MAX_VECTOR_LEN);
      expected_variances.push_back(r);
    end
    next_index = (next_index + 1) % MAX_VECTOR_LEN;
    if (last) restart_vector();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      half_w = 32'(swv_pkg::HALF_WINDOW_RST);
      restart_vector();
      expected_variances.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_variances.size() == 0) begin
          report_mismatch($sformatf("unexpected result variance=%0d centre=%0d",
                                    out_window_variance, out_centre_index));
        end else begin
          want = expected_variances.pop_front();
          if (out_window_variance !== want.variance || out_centre_index !== want.centre)
            report_mismatch($sformatf("variance %0d centre %0d, expected %0d centre %0d",
                                      out_window_variance, out_centre_index,
                                      want.variance, want.centre));
        end
      end
      // a write to the half window also starts a new vector
      if (psel && penable && pwrite && pready && paddr == swv_pkg::ADDR_HALF_WINDOW) begin
        half_w = 32'(pwdata[swv_pkg::HW_REG_W-1:0]);
        restart_vector();
      end
      if (in_valid && !in_stall) slide_window(in_sample, in_end_of_vector);
    end
    error_count     <= errors;
    pending_results <= expected_variances.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: clock, reset, sample and register stimulus for sliding_window_variance_top.
// Checking lives in swv_variance_checker; uses swv_pkg.
module tb_top;

  localparam int MAX_HALF_WINDOW = 127;
  localparam int MAX_VECTOR_LEN  = 65536;
  localparam int SETTLE_CYCLES   = 50;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 9;
  localparam int CALM_PHASES     = 2;
  localparam int PHASE_ITEMS     = 60;
  localparam int WIDE_VECTOR_LEN = 262;
  localparam logic [swv_pkg::CFG_AW-1:0] ADDR_UNUSED_FIRST =
    swv_pkg::ADDR_HALF_WINDOW + 1'b1;
  localparam logic signed [swv_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [swv_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;

  typedef enum {MIX_FULL, MIX_SMALL, MIX_EXTREME, MIX_FLAT} sample_mix_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [swv_pkg::SAMPLE_W-1:0] in_sample;
  logic                                in_end_of_vector;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [swv_pkg::VAR_W-1:0]           out_window_variance;
  logic [swv_pkg::CIDX_W-1:0]          out_centre_index;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [swv_pkg::CFG_AW-1:0]          paddr;
  logic [swv_pkg::CFG_DW-1:0]          pwdata;
  logic [swv_pkg::CFG_DW-1:0]          prdata;
  logic                                pready;

  int   error_count;
  int   pending_results;
  int   quiet_cycles     = 0;
  int   results_seen     = 0;
  int   samples_sent     = 0;
  int   vectors_closed   = 0;
  int   settings_written = 0;
  int   gap_pct          = 0;
  logic stall_on         = 1'b0;
  int   stall_left       = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sliding_window_variance_top #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .MAX_VECTOR_LEN (MAX_VECTOR_LEN)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_end_of_vector   (in_end_of_vector),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_variance(out_window_variance),
    .out_centre_index   (out_centre_index),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  swv_variance_checker #(
    .MAX_HALF_WINDOW(MAX_HALF_WINDOW),
    .MAX_VECTOR_LEN (MAX_VECTOR_LEN)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_end_of_vector   (in_end_of_vector),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_window_variance(out_window_variance),
    .out_centre_index   (out_centre_index),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .error_count        (error_count),
    .pending_results    (pending_results)
  );

  // result-side stall: random bursts, each either stalled or open
  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 1) == 1);
      stall_left <= $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) results_seen <= results_seen + 1;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic signed [swv_pkg::SAMPLE_W-1:0] draw_sample(
    input sample_mix_t mix, input logic signed [swv_pkg::SAMPLE_W-1:0] level);
    case (mix)
      MIX_SMALL:   return swv_pkg::SAMPLE_W'($urandom_range(0, 127) - 64);
      MIX_EXTREME: return ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : SAMPLE_MIN;
      MIX_FLAT:    return ($urandom_range(0, 7) == 0) ? level + 1'b1 : level;
      default:     return swv_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic signed [swv_pkg::SAMPLE_W-1:0] s, input logic last);
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= s;
    in_end_of_vector <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (last) vectors_closed++;
  endtask

  task automatic send_vector(input int len, input bit close);
    sample_mix_t                         mix;
    logic signed [swv_pkg::SAMPLE_W-1:0] level;
    mix   = sample_mix_t'($urandom_range(0, 3));
    level = swv_pkg::SAMPLE_W'($urandom());
    for (int i = 0; i < len; i++)
      send_sample(draw_sample(mix, level), close && (i == len - 1));
  endtask

  task automatic write_reg(input logic [swv_pkg::CFG_AW-1:0] addr,
                           input logic [swv_pkg::CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == swv_pkg::ADDR_HALF_WINDOW) settings_written++;
  endtask

  // hold off until every predicted result is out, then let a result-less
  // sample finish inside the block
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int h;
    int len;
    int phase_items;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_sample        = '0;
    in_end_of_vector = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (8) @(posedge clk);
    rst_n    <= 1'b1;
    stall_on <= 1'b1;
    gap_pct   = 25;
    @(posedge clk);

    // half window 1 after reset: full-scale swings saturate, flat runs give zero
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    // vector shorter than the window, then one just long enough
    send_sample(16'sd5, 1'b0);
    send_sample(16'sd9, 1'b1);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd7, 1'b1);
    wait_drained();

    // zero half window behaves as one
    write_reg(swv_pkg::ADDR_HALF_WINDOW, '0);
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd2, 1'b0);
    wait_drained();
    // unused addresses must leave the open vector alone
    for (int a = ADDR_UNUSED_FIRST; a < (1 << swv_pkg::CFG_AW); a++)
      write_reg(a[swv_pkg::CFG_AW-1:0], $urandom());
    send_sample(16'sd3, 1'b1);
    wait_drained();

    // widest window, upper data bits set
    write_reg(swv_pkg::ADDR_HALF_WINDOW, 32'hFFFF_FF80 | MAX_HALF_WINDOW);
    send_vector(WIDE_VECTOR_LEN, 1'b1);
    wait_drained();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      if (ph >= RANDOM_PHASES - CALM_PHASES) begin
        gap_pct   = 0;
        stall_on <= 1'b0;
      end else begin
        gap_pct   = $urandom_range(0, 3) * 15;
        stall_on <= ($urandom_range(0, 3) != 0);
      end
      write_reg(swv_pkg::ADDR_HALF_WINDOW, ($urandom() & ~32'h7F) | h);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        len = $urandom_range(1, 3 * h + 8);
        // an unclosed vector runs on, or is cut off by the next register write
        send_vector(len, $urandom_range(0, 5) != 0);
        phase_items += len;
        if (ph < RANDOM_PHASES - CALM_PHASES && $urandom_range(0, 7) == 0) wait_drained();
      end
      wait_drained();
    end

    $display("Run summary: %0d samples, %0d vectors closed by end-of-vector,",
             samples_sent, vectors_closed);
    $display("Run summary: %0d half-window writes, %0d variance results compared",
             settings_written, results_seen);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
